### design/s2cd_pkg.sv
// ----------------------------------------------------------------------------
// s2cd_pkg
// Shared constants and helpers for the seconds to calendar date converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

  typedef logic [8:0] doy_t;

  // seconds split: 86400 = 128 * 675
  localparam int unsigned SEC_LO_BITS = 7;
  localparam logic [9:0]  DAY_DIV     = 10'd675;
  localparam logic [15:0] DAY_MUL     = 16'd49710;   // floor(2^25 / 675)
  localparam int unsigned DAY_SHIFT   = 25;

  // four-year blocks of 1461 days
  localparam logic [10:0] BLOCK_DAYS  = 11'd1461;
  localparam logic [9:0]  BLOCK_MUL   = 10'd717;     // floor(2^20 / 1461)
  localparam int unsigned BLOCK_SHIFT = 20;

  // hours: 3600 = 16 * 225
  localparam logic [7:0]  HOUR_DIV    = 8'd225;
  localparam logic [5:0]  HOUR_MUL    = 6'd36;       // floor(2^13 / 225)

  // minutes: 60 = 4 * 15
  localparam logic [3:0]  MIN_DIV     = 4'd15;
  localparam logic [6:0]  MIN_MUL     = 7'd68;       // floor(2^10 / 15)

  localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
  localparam logic [10:0] DAYS_TWO_YEARS = 11'd731;
  localparam logic [10:0] DAYS_THREE_YEARS = 11'd1096;
  localparam logic [11:0] BASE_YEAR   = 12'd2000;

  localparam doy_t MONTH_START_COMMON [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // first day index of a month within its year
  function automatic doy_t month_start(input logic leap, input logic [3:0] idx);
    doy_t base;
    base = MONTH_START_COMMON[idx];
    if (leap && (idx >= 4'd2)) begin
      return base + 9'd1;
    end
    return base;
  endfunction

endpackage

### design/s2cd_month.sv
// ----------------------------------------------------------------------------
// s2cd_month
// Day of year to month and day of month, by parallel compares against the
// month start table.
// ----------------------------------------------------------------------------
module s2cd_month (
  input  logic [8:0] doy,
  input  logic       leap,
  output logic [3:0] month,
  output logic [4:0] day_of_month
);

  logic [3:0] cnt;
  logic [8:0] start;
  logic [8:0] offs;

  always_comb begin
    cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= s2cd_pkg::month_start(leap, 4'(k))) begin
        cnt = cnt + 4'd1;
      end
    end
    start        = s2cd_pkg::month_start(leap, cnt);
    offs         = doy - start;
    month        = cnt + 4'd1;
    day_of_month = offs[4:0] + 5'd1;
  end

endmodule

### design/seconds_to_calendar_date.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Six register stages from input accept to output valid.
// Throughput: one word per cycle; each stage holds while its successor is
// full and stalled, so bubbles are squeezed out and nothing is dropped.
// Rate is set by the reciprocal multiply and correct steps, one per stage.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_elapsed_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_sec_of_minute
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: estimate days = (secs >> 7) / 675
  logic [24:0] x1_r;
  logic [6:0]  lo1_r;
  logic [40:0] p1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r  <= in_elapsed_seconds[31:s2cd_pkg::SEC_LO_BITS];
      lo1_r <= in_elapsed_seconds[s2cd_pkg::SEC_LO_BITS-1:0];
      p1_r  <= {16'd0, in_elapsed_seconds[31:s2cd_pkg::SEC_LO_BITS]}
               * {25'd0, s2cd_pkg::DAY_MUL};
    end
  end

  // stage 2: correct the day estimate, form time of day
  logic [15:0] qd;
  logic [25:0] r26;
  logic [10:0] rd;
  logic [15:0] days2_nxt;
  logic [9:0]  remd;
  logic [15:0] days2_r;
  logic [16:0] tod2_r;

  always_comb begin
    qd  = p1_r[40:s2cd_pkg::DAY_SHIFT];
    r26 = {1'b0, x1_r} - ({10'd0, qd} * {16'd0, s2cd_pkg::DAY_DIV});
    rd  = r26[10:0];
    if (rd >= {1'b0, s2cd_pkg::DAY_DIV}) begin
      days2_nxt = qd + 16'd1;
      rd        = rd - {1'b0, s2cd_pkg::DAY_DIV};
    end else begin
      days2_nxt = qd;
    end
    remd = rd[9:0];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      days2_r <= days2_nxt;
      tod2_r  <= {remd, lo1_r};
    end
  end

  // stage 3: estimates for block and hour
  logic [15:0] days3_r;
  logic [16:0] tod3_r;
  logic [25:0] p2_r;
  logic [18:0] ph_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      days3_r <= days2_r;
      tod3_r  <= tod2_r;
      p2_r    <= {10'd0, days2_r} * {16'd0, s2cd_pkg::BLOCK_MUL};
      ph_r    <= {6'd0, tod2_r[16:4]} * {13'd0, s2cd_pkg::HOUR_MUL};
    end
  end

  // stage 4: correct block and hour
  logic [5:0]  blk_e;
  logic [16:0] r17;
  logic [5:0]  blk4_nxt;
  logic [10:0] d4_nxt;
  logic [4:0]  hour_e;
  logic [13:0] rh14;
  logic [4:0]  hour4_nxt;
  logic [7:0]  rh8;
  logic [5:0]  blk4_r;
  logic [10:0] d4_r;
  logic [4:0]  hour4_r;
  logic [11:0] remh4_r;

  always_comb begin
    blk_e = p2_r[25:s2cd_pkg::BLOCK_SHIFT];
    r17   = {1'b0, days3_r} - ({11'd0, blk_e} * {6'd0, s2cd_pkg::BLOCK_DAYS});
    if (r17 >= {6'd0, s2cd_pkg::BLOCK_DAYS}) begin
      blk4_nxt = blk_e + 6'd1;
      r17      = r17 - {6'd0, s2cd_pkg::BLOCK_DAYS};
    end else begin
      blk4_nxt = blk_e;
    end
    d4_nxt = r17[10:0];

    hour_e = ph_r[17:13];
    rh14   = {1'b0, tod3_r[16:4]} - ({9'd0, hour_e} * {6'd0, s2cd_pkg::HOUR_DIV});
    if (rh14 >= {6'd0, s2cd_pkg::HOUR_DIV}) begin
      hour4_nxt = hour_e + 5'd1;
      rh14      = rh14 - {6'd0, s2cd_pkg::HOUR_DIV};
    end else begin
      hour4_nxt = hour_e;
    end
    rh8 = rh14[7:0];
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      blk4_r  <= blk4_nxt;
      d4_r    <= d4_nxt;
      hour4_r <= hour4_nxt;
      remh4_r <= {rh8, tod3_r[3:0]};
    end
  end

  // stage 5: year within block, minute estimate
  logic [1:0]  yib5_nxt;
  logic [10:0] doy_full;
  logic        leap5_nxt;
  logic [5:0]  blk5_r;
  logic [1:0]  yib5_r;
  s2cd_pkg::doy_t doy5_r;
  logic        leap5_r;
  logic [4:0]  hour5_r;
  logic [11:0] remh5_r;
  logic [16:0] pm5_r;

  always_comb begin
    leap5_nxt = 1'b0;
    priority if (d4_r < s2cd_pkg::DAYS_LEAP_YEAR) begin
      yib5_nxt  = 2'd0;
      doy_full  = d4_r;
      leap5_nxt = 1'b1;
    end else if (d4_r < s2cd_pkg::DAYS_TWO_YEARS) begin
      yib5_nxt = 2'd1;
      doy_full = d4_r - s2cd_pkg::DAYS_LEAP_YEAR;
    end else if (d4_r < s2cd_pkg::DAYS_THREE_YEARS) begin
      yib5_nxt = 2'd2;
      doy_full = d4_r - s2cd_pkg::DAYS_TWO_YEARS;
    end else begin
      yib5_nxt = 2'd3;
      doy_full = d4_r - s2cd_pkg::DAYS_THREE_YEARS;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      blk5_r  <= blk4_r;
      yib5_r  <= yib5_nxt;
      doy5_r  <= doy_full[8:0];
      leap5_r <= leap5_nxt;
      hour5_r <= hour4_r;
      remh5_r <= remh4_r;
      pm5_r   <= {7'd0, remh4_r[11:2]} * {10'd0, s2cd_pkg::MIN_MUL};
    end
  end

  // stage 6: correct minute, month lookup, year, output word
  logic [5:0]  min_e;
  logic [9:0]  rm10;
  logic [5:0]  min6_nxt;
  logic [3:0]  month6_nxt;
  logic [4:0]  day6_nxt;
  logic [11:0] year6_nxt;

  s2cd_month u_month (
    .doy          (doy5_r),
    .leap         (leap5_r),
    .month        (month6_nxt),
    .day_of_month (day6_nxt)
  );

  always_comb begin
    min_e = pm5_r[15:10];
    rm10  = remh5_r[11:2] - ({4'd0, min_e} * {6'd0, s2cd_pkg::MIN_DIV});
    if (rm10 >= {6'd0, s2cd_pkg::MIN_DIV}) begin
      min6_nxt = min_e + 6'd1;
      rm10     = rm10 - {6'd0, s2cd_pkg::MIN_DIV};
    end else begin
      min6_nxt = min_e;
    end
    year6_nxt = s2cd_pkg::BASE_YEAR + {4'd0, blk5_r, 2'b00} + {10'd0, yib5_r};
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_year          <= year6_nxt;
      out_month         <= month6_nxt;
      out_day_of_month  <= day6_nxt;
      out_hour          <= hour5_r;
      out_minute        <= min6_nxt;
      out_sec_of_minute <= {rm10[3:0], remh5_r[1:0]};
    end
  end

  // checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12))
    else $error("month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59)
                  && (out_sec_of_minute <= 6'd59) && (out_day_of_month != 5'd0))
    else $error("time of day out of range");

  a_february: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_month == 4'd2) |-> (out_day_of_month <= 5'd29))
    else $error("february day out of range");

endmodule
